FILE: src/cbmt_pkg.sv
// ----------------------------------------------------------------------------
// cbmt_pkg: shared definitions for the counter bank with max tracking
// Sizes, command codes and the small types passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cbmt_pkg;

   localparam int COUNTERS   = 64;
   localparam int COUNT_BITS = 16;

   localparam int IDX_W  = (COUNTERS > 1) ? $clog2(COUNTERS) : 1;
   localparam int HOLD_W = $clog2(COUNTERS + 1);
   localparam int CMD_W  = 3;
   localparam int REQ_IDX_W = 6;

   typedef logic signed [COUNT_BITS-1:0] cnt_type;
   typedef logic [IDX_W-1:0]             addr_type;
   typedef logic [HOLD_W-1:0]            hold_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_INC   = 3'd0,
      CMD_DEC   = 3'd1,
      CMD_ZERO  = 3'd2,
      CMD_QUERY = 3'd3,
      CMD_LIST  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      OP_INC,
      OP_DEC,
      OP_ZERO,
      OP_KEEP
   } op_type;

   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UPDATE,
      S_ADJUST,
      S_SCAN_ADDR,
      S_SCAN_DATA,
      S_LIST_ADDR,
      S_LIST_DATA,
      S_RESP
   } state_type;

   localparam cnt_type CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam cnt_type CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

endpackage

`default_nettype wire

FILE: src/cbmt_store.sv
// ----------------------------------------------------------------------------
// cbmt_store: counter memory
// One write and one registered read port; per-entry valid bits make
// never-written counters read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cbmt_store (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire cbmt_pkg::addr_type wr_addr,
   input  wire cbmt_pkg::cnt_type  wr_data,
   input  wire logic               rd_en,
   input  wire cbmt_pkg::addr_type rd_addr,
   output cbmt_pkg::cnt_type       rd_data
);
   import cbmt_pkg::*;

   cnt_type              mem [COUNTERS];
   logic [COUNTERS-1:0]  valid_ff;
   cnt_type              rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

FILE: src/cbmt_alu.sv
// ----------------------------------------------------------------------------
// cbmt_alu: shared arithmetic and compare unit
// Saturating step of one counter, plus one signed compare reused by the
// update, rescan and list sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module cbmt_alu (
   input  wire cbmt_pkg::op_type  op,
   input  wire cbmt_pkg::cnt_type value,
   input  wire cbmt_pkg::cnt_type cmp_a,
   input  wire cbmt_pkg::cnt_type cmp_b,
   output cbmt_pkg::cnt_type      result,
   output logic                   changed,
   output cbmt_pkg::cmp_type      cmp
);
   import cbmt_pkg::*;

   always_comb begin
      result  = value;
      changed = 1'b0;
      case (op)
         OP_INC: begin
            if (value != CNT_MAX) begin
               result  = value + cnt_type'(1);
               changed = 1'b1;
            end
         end
         OP_DEC: begin
            if (value != CNT_MIN) begin
               result  = value - cnt_type'(1);
               changed = 1'b1;
            end
         end
         OP_ZERO: begin
            result  = '0;
            changed = (value != '0);
         end
         default: begin
            result  = value;
            changed = 1'b0;
         end
      endcase
   end

   // signed compare, gt in the upper bit and eq in the lower
   assign cmp = {(cmp_a > cmp_b), (cmp_a == cmp_b)};

endmodule

`default_nettype wire

FILE: src/counter_bank_with_max_tracking.sv
// ----------------------------------------------------------------------------
// counter_bank_with_max_tracking: bank of saturating counters with max tracking
// Sequencer around a counter memory and one shared step/compare unit.
// ----------------------------------------------------------------------------
// A bank of 64 signed 16-bit counters, all zero after reset. Each request beat
// carries a command (increment, decrement, reset to zero, query, list) and a
// counter index. Every command but list gives one response beat with the
// counter's value, the maximum over the bank and how many counters hold it.
// List gives one beat per counter at the maximum, ascending by index, with
// rsp_last on the final one. When the only counter at the maximum drops
// below it, the bank is rescanned through the single memory read port, one
// counter per cycle. A list walks the memory at one counter per cycle while
// the response side keeps up, and stops early when the last holder is
// sent. A new request beat is taken once the block is back in idle, even
// while the previous response beat still waits in the output register. No
// clearing pass is needed after reset: per-entry valid bits stand in for
// zero.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_bank_with_max_tracking (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [cbmt_pkg::CMD_W-1:0]        req_command,
   input  wire logic [cbmt_pkg::REQ_IDX_W-1:0]    req_counter_index,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output cbmt_pkg::cnt_type                      rsp_counter_value,
   output cbmt_pkg::cnt_type                      rsp_max_value,
   output cbmt_pkg::hold_type                     rsp_max_holders,
   output logic [cbmt_pkg::REQ_IDX_W-1:0]         rsp_listed_index,
   output logic                                   rsp_last
);
   import cbmt_pkg::*;

   state_type  state_ff, state_in;

   // captured request
   logic [CMD_W-1:0] cmd_ff;
   addr_type         idx_ff;

   // tracked maximum
   cnt_type    max_ff;
   hold_type   holders_ff;

   // update scratch
   cnt_type    new_ff;
   logic       changed_ff;
   logic       old_at_max_ff;

   // walk state, shared by rescan and list
   addr_type   k_ff;
   cnt_type    scan_m_ff;
   hold_type   scan_n_ff;
   hold_type   emitted_ff;

   // response register
   logic       rsp_valid_ff;
   cnt_type    rsp_value_ff;
   cnt_type    rsp_max_ff;
   hold_type   rsp_holders_ff;
   addr_type   rsp_idx_ff;
   logic       rsp_last_ff;

   // memory and unit hookup
   logic       rd_en;
   addr_type   rd_addr;
   cnt_type    rd_data;
   logic       wr_en;
   op_type     alu_op;
   cnt_type    alu_result;
   logic       alu_changed;
   cnt_type    cmp_a;
   cnt_type    cmp_b;
   cmp_type    cmp;

   // control terms
   logic       accept;
   logic       req_oor;
   logic       can_load;
   logic       rsp_load;
   logic       list_hit;
   logic       list_last;
   logic       walk_end;
   logic       advance;
   addr_type   k_next;
   cnt_type    scan_m_in;
   hold_type   scan_n_in;

   cbmt_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (alu_result),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cbmt_alu u_alu (
      .op      (alu_op),
      .value   (rd_data),
      .cmp_a   (cmp_a),
      .cmp_b   (cmp_b),
      .result  (alu_result),
      .changed (alu_changed),
      .cmp     (cmp)
   );

   assign accept    = req_valid && req_ready;
   assign req_oor   = ({1'b0, req_counter_index} >= (REQ_IDX_W+1)'(COUNTERS));
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign list_hit  = cmp.eq;
   assign list_last = ((emitted_ff + hold_type'(1)) == holders_ff);
   assign walk_end  = (k_ff == addr_type'(COUNTERS - 1));
   assign k_next    = k_ff + addr_type'(1);

   // command to step operation; unknown codes act as query
   always_comb begin
      case (cmd_ff)
         CMD_INC:  alu_op = OP_INC;
         CMD_DEC:  alu_op = OP_DEC;
         CMD_ZERO: alu_op = OP_ZERO;
         default:  alu_op = OP_KEEP;
      endcase
   end

   // running max/count of the rescan
   always_comb begin
      if (k_ff == '0 || cmp.gt) begin
         scan_m_in = rd_data;
         scan_n_in = hold_type'(1);
      end else if (cmp.eq) begin
         scan_m_in = scan_m_ff;
         scan_n_in = scan_n_ff + hold_type'(1);
      end else begin
         scan_m_in = scan_m_ff;
         scan_n_in = scan_n_ff;
      end
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = k_next;
      wr_en     = 1'b0;
      cmp_a     = rd_data;
      cmp_b     = max_ff;
      rsp_load  = 1'b0;
      advance   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            rd_en     = req_valid;
            rd_addr   = req_counter_index[IDX_W-1:0];
         end
         S_UPDATE: begin
            wr_en = 1'b1;
         end
         S_ADJUST: begin
            cmp_a = new_ff;
         end
         S_SCAN_ADDR: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         S_SCAN_DATA: begin
            cmp_b   = scan_m_ff;
            rd_en   = 1'b1;
            advance = 1'b1;
         end
         S_LIST_ADDR: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         S_LIST_DATA: begin
            rsp_load = list_hit && can_load;
            advance  = !list_hit || can_load;
            rd_en    = advance;
         end
         S_RESP: begin
            rsp_load = can_load;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_command == CMD_LIST) begin
                  state_in = S_LIST_ADDR;
               end else if (req_oor) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_UPDATE: begin
            state_in = S_ADJUST;
         end
         S_ADJUST: begin
            if (changed_ff && !cmp.gt && !cmp.eq && old_at_max_ff &&
                holders_ff == hold_type'(1)) begin
               state_in = S_SCAN_ADDR;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SCAN_ADDR: begin
            state_in = S_SCAN_DATA;
         end
         S_SCAN_DATA: begin
            if (walk_end) begin
               state_in = S_RESP;
            end
         end
         S_LIST_ADDR: begin
            state_in = S_LIST_DATA;
         end
         S_LIST_DATA: begin
            if ((rsp_load && list_last) || (advance && walk_end)) begin
               state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (can_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_ff       <= '0;
         holders_ff   <= hold_type'(COUNTERS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_ADJUST: begin
               if (changed_ff) begin
                  if (cmp.gt) begin
                     max_ff     <= new_ff;
                     holders_ff <= hold_type'(1);
                  end else if (cmp.eq) begin
                     holders_ff <= holders_ff + hold_type'(1);
                  end else if (old_at_max_ff && holders_ff != hold_type'(1)) begin
                     holders_ff <= holders_ff - hold_type'(1);
                  end
               end
            end
            S_SCAN_DATA: begin
               if (walk_end) begin
                  max_ff     <= scan_m_in;
                  holders_ff <= scan_n_in;
               end
            end
            default: begin
               max_ff <= max_ff;
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_ff     <= req_command;
               idx_ff     <= req_counter_index[IDX_W-1:0];
               new_ff     <= '0;
               k_ff       <= '0;
               emitted_ff <= '0;
            end
         end
         S_UPDATE: begin
            new_ff        <= alu_result;
            changed_ff    <= alu_changed;
            old_at_max_ff <= cmp.eq;
         end
         S_SCAN_ADDR: begin
            k_ff <= '0;
         end
         S_SCAN_DATA: begin
            scan_m_ff <= scan_m_in;
            scan_n_ff <= scan_n_in;
            k_ff      <= k_next;
         end
         S_LIST_DATA: begin
            if (advance) begin
               k_ff <= k_next;
            end
            if (rsp_load) begin
               emitted_ff <= emitted_ff + hold_type'(1);
            end
         end
         default: begin
            k_ff <= k_ff;
         end
      endcase
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_max_ff     <= max_ff;
         rsp_holders_ff <= holders_ff;
         if (state_ff == S_LIST_DATA) begin
            rsp_value_ff <= rd_data;
            rsp_idx_ff   <= k_ff;
            rsp_last_ff  <= list_last;
         end else begin
            rsp_value_ff <= new_ff;
            rsp_idx_ff   <= '0;
            rsp_last_ff  <= 1'b1;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_counter_value = rsp_value_ff;
   assign rsp_max_value     = rsp_max_ff;
   assign rsp_max_holders   = rsp_holders_ff;
   assign rsp_listed_index  = REQ_IDX_W'(rsp_idx_ff);
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

FILE: test/counter_bank_with_max_tracking_test.sv
// ----------------------------------------------------------------------------
// counter_bank_with_max_tracking_test: self-checking bench for the counter bank
// Drives command beats and checks every response beat against a predictor that
// tracks its own copy of the 64 counters, their maximum and the holder count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module counter_bank_with_max_tracking_test;
   import cbmt_pkg::*;

   // Commands above list have no meaning of their own; the block treats them
   // as a query.
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_W'(CMD_LIST + 1);
   localparam logic [CMD_W-1:0] CMD_SPARE_MID   = CMD_W'(CMD_LIST + 2);
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = CMD_W'((1 << CMD_W) - 1);

   localparam int RANDOM_ITEMS = 255;
   localparam int QUIET_TAIL   = 40;   // last random beats run without idling
   localparam int HOLD_AT_ITEM = 60;   // where the long response hold-off starts
   localparam int LONG_HOLD    = 200;  // cycles of rsp_ready low in that hold-off
   localparam int STALL_LIMIT  = 4000; // cycles without any beat before giving up
   localparam int DRAIN_CYCLES = 100;  // covers a full rescan or list walk

   typedef struct {
      cnt_type                value;
      cnt_type                top;
      hold_type               holders;
      logic [REQ_IDX_W-1:0]   listed;
      logic                   last;
   } bank_reply_type;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the counter bank and queues the response beats that
   // each accepted command beat must produce.
   // -------------------------------------------------------------------------
   class bank_tracker_type;
      cnt_type        counts[COUNTERS];
      cnt_type        peak;
      hold_type       peak_count;
      bank_reply_type pending_beats[$];
      int             mismatches;

      function new();
         foreach (counts[k]) counts[k] = '0;
         peak       = '0;
         peak_count = hold_type'(COUNTERS);
         mismatches = 0;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      function void find_peak();
         peak = counts[0];
         foreach (counts[k]) if (counts[k] > peak) peak = counts[k];
         peak_count = '0;
         foreach (counts[k]) if (counts[k] == peak) peak_count++;
      endfunction

      function void take_request(logic [CMD_W-1:0] cmd, logic [REQ_IDX_W-1:0] idx);
         bank_reply_type beat;
         int             seen;
         if (cmd == CMD_LIST) begin
            // one beat per holder of the maximum, ascending index
            seen = 0;
            foreach (counts[k]) begin
               if (counts[k] == peak) begin
                  seen++;
                  beat = '{counts[k], peak, peak_count, REQ_IDX_W'(k),
                           seen == int'(peak_count)};
                  pending_beats.insert(pending_beats.size(), beat);
               end
            end
         end else begin
            case (cmd)
               CMD_INC:
                  if (counts[idx] != CNT_MAX) counts[idx] = counts[idx] + cnt_type'(1);
               CMD_DEC:
                  if (counts[idx] != CNT_MIN) counts[idx] = counts[idx] - cnt_type'(1);
               CMD_ZERO: counts[idx] = '0;
               default: ;
            endcase
            find_peak();
            beat = '{counts[idx], peak, peak_count, '0, 1'b1};
            pending_beats.insert(pending_beats.size(), beat);
         end
      endfunction

      task match_response(cnt_type value, cnt_type top, hold_type holders,
                          logic [REQ_IDX_W-1:0] listed, logic last);
         bank_reply_type want;
         if (pending_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat, value %0d listed %0d",
                                      value, listed));
            return;
         end
         want = pending_beats[0];
         pending_beats.delete(0);
         if (value !== want.value)
            report_mismatch($sformatf("counter_value %0d, want %0d", value, want.value));
         if (top !== want.top)
            report_mismatch($sformatf("max_value %0d, want %0d", top, want.top));
         if (holders !== want.holders)
            report_mismatch($sformatf("max_holders %0d, want %0d", holders, want.holders));
         if (listed !== want.listed)
            report_mismatch($sformatf("listed_index %0d, want %0d", listed, want.listed));
         if (last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", last, want.last));
      endtask

      function int outstanding();
         return pending_beats.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test and its stimulus signals
   // -------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CMD_W-1:0]       req_command = '0;
   logic [REQ_IDX_W-1:0]   req_counter_index = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   cnt_type                rsp_counter_value;
   cnt_type                rsp_max_value;
   hold_type               rsp_max_holders;
   logic [REQ_IDX_W-1:0]   rsp_listed_index;
   logic                   rsp_last;

   bank_tracker_type tracker = new();

   bit quiet;             // no idling on either side while set
   bit long_hold_wanted;  // stimulus asks the response side for a long hold-off

   counter_bank_with_max_tracking uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_counter_index (req_counter_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_counter_value (rsp_counter_value),
      .rsp_max_value     (rsp_max_value),
      .rsp_max_holders   (rsp_max_holders),
      .rsp_listed_index  (rsp_listed_index),
      .rsp_last          (rsp_last)
   );

   always #4 clock = ~clock;

   // -------------------------------------------------------------------------
   // Command side. Valid stays up across back-to-back beats; an idle burst
   // drops it before the next beat is offered. The beat is logged with the
   // predictor at the edge where it is taken.
   // -------------------------------------------------------------------------
   task automatic send_beat(logic [CMD_W-1:0] cmd, logic [REQ_IDX_W-1:0] idx);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_counter_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_request(cmd, idx);
   endtask

   // Random beat: mostly updates on a handful of counters so the maximum moves
   // around and lists stay short; full index range now and then.
   task automatic send_random_beat();
      int                   pick;
      logic [CMD_W-1:0]     cmd;
      logic [REQ_IDX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      if (pick < 35)      cmd = CMD_INC;
      else if (pick < 60) cmd = CMD_DEC;
      else if (pick < 68) cmd = CMD_ZERO;
      else if (pick < 78) cmd = CMD_QUERY;
      else if (pick < 90) cmd = CMD_LIST;
      else                cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      if ($urandom_range(0, 3) != 0) idx = REQ_IDX_W'($urandom_range(0, 7));
      else                           idx = REQ_IDX_W'($urandom_range(0, COUNTERS - 1));
      send_beat(cmd, idx);
   endtask

   // -------------------------------------------------------------------------
   // Response side: checks each taken beat, then picks rsp_ready for the next
   // cycle. Short random stalls, plus one long hold-off on request so the
   // block backs up and stalls the command side.
   // -------------------------------------------------------------------------
   initial begin : response_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else begin
            if (rsp_valid && rsp_ready)
               tracker.match_response(rsp_counter_value, rsp_max_value,
                                      rsp_max_holders, rsp_listed_index, rsp_last);
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else if (long_hold_wanted) begin
               long_hold_wanted = 1'b0;
               stall_left = LONG_HOLD - 1;
               rsp_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
               stall_left = $urandom_range(1, 4) - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: a run where no beat moves on either side for too long is hung.
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles, %0d still expected",
                     $time, idle_cycles, tracker.outstanding());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      quiet            = 1'b0;
      long_hold_wanted = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fresh bank (all 64 tied at zero), every command, sole max
      // holder dropping back, negative values, ties, unused command codes.
      send_beat(CMD_QUERY, 0);
      send_beat(CMD_LIST, 63);
      send_beat(CMD_INC, 63);
      send_beat(CMD_INC, 63);
      send_beat(CMD_LIST, 0);
      send_beat(CMD_QUERY, 0);
      send_beat(CMD_DEC, 63);
      send_beat(CMD_DEC, 63);
      send_beat(CMD_DEC, 0);
      send_beat(CMD_QUERY, 0);
      send_beat(CMD_LIST, 42);
      send_beat(CMD_ZERO, 0);
      send_beat(CMD_ZERO, 63);
      send_beat(CMD_SPARE_FIRST, 42);
      send_beat(CMD_SPARE_MID, 21);
      send_beat(CMD_SPARE_LAST, 63);
      send_beat(CMD_INC, 0);
      send_beat(CMD_INC, 1);
      send_beat(CMD_INC, 2);
      send_beat(CMD_LIST, 21);
      send_beat(CMD_DEC, 1);
      send_beat(CMD_LIST, 63);
      send_beat(CMD_ZERO, 2);
      send_beat(CMD_ZERO, 0);
      send_beat(CMD_QUERY, 63);

      // Random part, with one long response hold-off early and a tail
      // without idling.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_AT_ITEM) long_hold_wanted = 1'b1;
         if (n == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
         send_random_beat();
      end
      req_valid <= 1'b0;

      while (tracker.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
